// ----- hw/rtl/flat_bottom_distance_restraint_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the restraint block
// Clocked assertion helpers, reset-gated, used by the top-level restraint file.
// ----------------------------------------------------------------------------
`ifndef FLAT_BOTTOM_DISTANCE_RESTRAINT_DEFINES_SVH
`define FLAT_BOTTOM_DISTANCE_RESTRAINT_DEFINES_SVH

// property holds at every edge out of reset
`define FBDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition never seen
`define FBDR_ASSERT_NEVER(lbl, cond, msg) `FBDR_ASSERT(lbl, !(cond), msg)

`endif

// ----- hw/rtl/fbdr_pkg.sv -----
// ----------------------------------------------------------------------------
// Restraint block package
// Item types, result codes, register indexes and shared helpers.
// ----------------------------------------------------------------------------
package fbdr_pkg;

  localparam int unsigned MAX_LAMBDA_STATES = 4;
  localparam int unsigned NUM_WEIGHT_REGS   = 4;
  localparam logic [16:0] WEIGHT_ONE        = 17'd65536;

  localparam logic [2:0] REG_COUNT   = 3'd0;
  localparam logic [2:0] REG_WEIGHT0 = 3'd1;

  localparam logic [1:0] KIND_FORCE = 2'd0;
  localparam logic [1:0] KIND_STATE = 2'd1;
  localparam logic [1:0] KIND_PLAIN = 2'd2;

  // shared multiplier geometry
  localparam int unsigned MUL_AW = 84;
  localparam int unsigned MUL_BW = 33;
  localparam int unsigned MUL_CW = 28;
  localparam int unsigned MUL_NC = MUL_AW / MUL_CW;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [30:0]        lower_bound;
    logic [30:0]        upper_bound;
    logic [31:0]        spring_const;
    logic [2:0]         lambda_select;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         state_index;
    logic signed [39:0] force_x;
    logic signed [39:0] force_y;
    logic signed [39:0] force_z;
    logic [47:0]        energy_value;
    logic               outside_bounds;
    logic               last_result;
  } out_item_t;

  // front to back record
  typedef struct packed {
    logic [39:0] force_x;
    logic [39:0] force_y;
    logic [39:0] force_z;
    logic [47:0] energy;
    logic        outside;
    logic [2:0]  sel;
    logic        last;
  } frec_t;

  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

endpackage

// ----- hw/rtl/fbdr_mul.sv -----
// ----------------------------------------------------------------------------
// Wide multiplier
// Unsigned wide-by-33 product, one 28-bit slice of A per cycle.
// ----------------------------------------------------------------------------
module fbdr_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fbdr_pkg::MUL_AW-1:0]   a_i,
  input  logic [fbdr_pkg::MUL_BW-1:0]   b_i,
  output logic                          done_o,
  output logic [fbdr_pkg::MUL_PW-1:0]   p_o
);
  import fbdr_pkg::*;

  localparam int unsigned CntW = $clog2(MUL_NC);

  logic [MUL_AW-1:0]       a_q;
  logic [MUL_BW-1:0]       b_q;
  logic [MUL_PW-1:0]       acc_q;
  logic [CntW-1:0]         cnt_q;
  logic                    busy_q, done_q;
  logic [MUL_CW-1:0]       chunk;
  logic [MUL_CW+MUL_BW-1:0] part;

  assign chunk = MUL_CW'(a_q >> (MUL_CW * cnt_q));
  assign part  = {{MUL_BW{1'b0}}, chunk} * {{MUL_CW{1'b0}}, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(MUL_NC - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(MUL_NC - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + (MUL_PW'(part) << (MUL_CW * cnt_q));
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ----- hw/rtl/fbdr_front.sv -----
// ----------------------------------------------------------------------------
// Restraint front end
// Takes an item, forms distance, classifies it and works out energy and force.
// ----------------------------------------------------------------------------
module fbdr_front #(
  parameter int unsigned MaxLambdaStates = fbdr_pkg::MAX_LAMBDA_STATES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fbdr_pkg::in_item_t  in_data_i,
  input  logic [16:0]         weight_i [MaxLambdaStates],
  output logic                push_o,
  output fbdr_pkg::frec_t     rec_o,
  input  logic                full_i
);
  import fbdr_pkg::*;

  localparam int unsigned IdxW = (MaxLambdaStates > 1) ? $clog2(MaxLambdaStates) : 1;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SQ   = 11'b00000000010,
    S_SQRT = 11'b00000000100,
    S_CLS  = 11'b00000001000,
    S_ENG1 = 11'b00000010000,
    S_ENG2 = 11'b00000100000,
    S_F1   = 11'b00001000000,
    S_F2   = 11'b00010000000,
    S_F3   = 11'b00100000000,
    S_DIV  = 11'b01000000000,
    S_PUSH = 11'b10000000000
  } fstate_e;

  function automatic logic [33:0] sub_mag(logic [31:0] p, logic [31:0] q);
    logic [32:0] d;
    d = {p[31], p} - {q[31], q};
    return {d[32], d[32] ? (33'd0 - d) : d};
  endfunction

  fstate_e            state_q;
  logic [1:0]         axis_q;
  logic               wait_q;
  logic [5:0]         cnt_q;
  logic [32:0]        amag_q [3];
  logic               aneg_q [3];
  logic [30:0]        lo_q, up_q;
  logic [31:0]        k_q;
  logic [16:0]        w_q;
  logic [2:0]         sel_q;
  logic               last_q;
  logic [65:0]        sum_q;
  logic [67:0]        srad_q;
  logic [37:0]        rem_q;
  logic [33:0]        root_q;
  logic               outside_q, dneg_q, fzero_q;
  logic [32:0]        dm_q;
  logic [47:0]        energy_q;
  logic [81:0]        prod_q;
  logic [38:0]        num_q [3];
  logic [34:0]        drem_q [3];
  logic               dsat_q [3];
  logic [38:0]        quo_q [3];
  logic               sgn_q [3];

  logic               mstart, mdone;
  logic [MUL_AW-1:0]  ma;
  logic [MUL_BW-1:0]  mb;
  logic [MUL_PW-1:0]  mp;
  logic [65:0]        sum_nx;
  logic [37:0]        rem_sh, trial;
  logic [16:0]        w_sel;
  logic [33:0]        dx, dy, dz;
  logic [39:0]        fval [3];

  fbdr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart),
    .a_i     (ma),
    .b_i     (mb),
    .done_o  (mdone),
    .p_o     (mp)
  );

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_SQ: begin
        ma = MUL_AW'(amag_q[axis_q]);
        mb = amag_q[axis_q];
      end
      S_ENG1: begin
        ma = MUL_AW'(dm_q);
        mb = dm_q;
      end
      S_ENG2, S_F2: begin
        ma = MUL_AW'(prod_q);
        mb = MUL_BW'(k_q);
      end
      S_F1: begin
        ma = MUL_AW'(amag_q[axis_q]);
        mb = MUL_BW'(w_q);
      end
      S_F3: begin
        ma = MUL_AW'(prod_q);
        mb = dm_q;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mstart = !wait_q && (state_q inside {S_SQ, S_ENG1, S_ENG2, S_F1, S_F2, S_F3});
  assign sum_nx = sum_q + mp[65:0];
  assign rem_sh = {rem_q[35:0], srad_q[67:66]};
  assign trial  = {2'b00, root_q, 2'b01};

  assign dx = sub_mag(in_data_i.second_x, in_data_i.first_x);
  assign dy = sub_mag(in_data_i.second_y, in_data_i.first_y);
  assign dz = sub_mag(in_data_i.second_z, in_data_i.first_z);

  always_comb begin
    if (in_data_i.lambda_select == 3'd0) begin
      w_sel = WEIGHT_ONE;
    end else if (4'(in_data_i.lambda_select) <= 4'(MaxLambdaStates)) begin
      w_sel = weight_i[IdxW'(in_data_i.lambda_select - 3'd1)];
    end else begin
      w_sel = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= '0;
      wait_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SQ;
            axis_q  <= '0;
            wait_q  <= 1'b0;
          end
        end
        S_SQ: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (mdone) begin
            wait_q <= 1'b0;
            if (axis_q == 2'd2) begin
              state_q <= S_SQRT;
              cnt_q   <= '0;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd33) state_q <= S_CLS;
        end
        S_CLS: begin
          if (root_q < {3'b000, lo_q} || root_q > {3'b000, up_q}) state_q <= S_ENG1;
          else state_q <= S_PUSH;
        end
        S_ENG1, S_F1, S_F2: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (mdone) begin
            wait_q <= 1'b0;
            case (state_q)
              S_ENG1:  state_q <= S_ENG2;
              S_F1:    state_q <= S_F2;
              default: state_q <= S_F3;
            endcase
          end
        end
        S_ENG2: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (mdone) begin
            wait_q <= 1'b0;
            axis_q <= '0;
            state_q <= (root_q == '0) ? S_PUSH : S_F1;
          end
        end
        S_F3: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (mdone) begin
            wait_q <= 1'b0;
            if (axis_q == 2'd2) begin
              state_q <= S_DIV;
              cnt_q   <= '0;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= S_F1;
            end
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd38) state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (!full_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          amag_q[0] <= dx[32:0];
          amag_q[1] <= dy[32:0];
          amag_q[2] <= dz[32:0];
          aneg_q[0] <= dx[33];
          aneg_q[1] <= dy[33];
          aneg_q[2] <= dz[33];
          lo_q      <= in_data_i.lower_bound;
          up_q      <= in_data_i.upper_bound;
          k_q       <= in_data_i.spring_const;
          w_q       <= w_sel;
          sel_q     <= in_data_i.lambda_select;
          last_q    <= in_data_i.last_item;
          sum_q     <= '0;
          outside_q <= 1'b0;
          fzero_q   <= 1'b1;
          energy_q  <= '0;
        end
      end
      S_SQ: begin
        if (wait_q && mdone) begin
          sum_q <= sum_nx;
          if (axis_q == 2'd2) begin
            srad_q <= {2'b00, sum_nx};
            rem_q  <= '0;
            root_q <= '0;
          end
        end
      end
      S_SQRT: begin
        srad_q <= {srad_q[65:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[32:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[32:0], 1'b0};
        end
      end
      S_CLS: begin
        if (root_q < {3'b000, lo_q}) begin
          outside_q <= 1'b1;
          dneg_q    <= 1'b1;
          dm_q      <= 33'({3'b000, lo_q} - root_q);
        end else if (root_q > {3'b000, up_q}) begin
          outside_q <= 1'b1;
          dneg_q    <= 1'b0;
          dm_q      <= 33'(root_q - {3'b000, up_q});
        end
      end
      S_ENG1: begin
        if (wait_q && mdone) prod_q <= 82'(mp[65:0]);
      end
      S_ENG2: begin
        if (wait_q && mdone) begin
          energy_q <= (|mp[97:89]) ? '1 : mp[88:41];
          fzero_q  <= (root_q == '0);
        end
      end
      S_F1: begin
        if (wait_q && mdone) prod_q <= 82'(mp[49:0]);
      end
      S_F2: begin
        if (wait_q && mdone) prod_q <= mp[81:0];
      end
      S_F3: begin
        if (wait_q && mdone) begin
          num_q[axis_q]  <= mp[74:36];
          drem_q[axis_q] <= 35'(mp[114:75]);
          dsat_q[axis_q] <= mp[114:75] >= 40'(root_q);
          sgn_q[axis_q]  <= aneg_q[axis_q] ^ dneg_q;
        end
      end
      S_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if ({drem_q[i][33:0], num_q[i][38]} >= {1'b0, root_q}) begin
            drem_q[i] <= {drem_q[i][33:0], num_q[i][38]} - {1'b0, root_q};
            quo_q[i]  <= {quo_q[i][37:0], 1'b1};
          end else begin
            drem_q[i] <= {drem_q[i][33:0], num_q[i][38]};
            quo_q[i]  <= {quo_q[i][37:0], 1'b0};
          end
          num_q[i] <= {num_q[i][37:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (fzero_q) fval[i] = '0;
      else if (sgn_q[i]) fval[i] = dsat_q[i] ? 40'h80_0000_0000 : (40'd0 - {1'b0, quo_q[i]});
      else fval[i] = dsat_q[i] ? 40'h7F_FFFF_FFFF : {1'b0, quo_q[i]};
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign push_o        = (state_q == S_PUSH) && !full_i;
  assign rec_o.force_x = fval[0];
  assign rec_o.force_y = fval[1];
  assign rec_o.force_z = fval[2];
  assign rec_o.energy  = energy_q;
  assign rec_o.outside = outside_q;
  assign rec_o.sel     = sel_q;
  assign rec_o.last    = last_q;

endmodule

// ----- hw/rtl/fbdr_queue.sv -----
// ----------------------------------------------------------------------------
// Front to back queue
// Two-entry FIFO of finished restraint records.
// ----------------------------------------------------------------------------
module fbdr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fbdr_pkg::frec_t  data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output fbdr_pkg::frec_t  data_o
);
  import fbdr_pkg::*;

  frec_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rptr_q];

endmodule

// ----- hw/rtl/fbdr_back.sv -----
// ----------------------------------------------------------------------------
// Restraint back end
// Accumulates energy per lambda state and emits results and totals.
// ----------------------------------------------------------------------------
module fbdr_back #(
  parameter int unsigned MaxLambdaStates = fbdr_pkg::MAX_LAMBDA_STATES,
  localparam int unsigned CntW = $clog2(MaxLambdaStates + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CntW-1:0]      n_i,
  input  logic                 empty_i,
  input  fbdr_pkg::frec_t      rec_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fbdr_pkg::out_item_t  out_data_o
);
  import fbdr_pkg::*;

  localparam int unsigned IdxW = (MaxLambdaStates > 1) ? $clog2(MaxLambdaStates) : 1;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_TOT  = 2'b10
  } bstate_e;

  bstate_e     state_q;
  logic [47:0] ssum_q [MaxLambdaStates];
  logic [47:0] psum_q;
  logic [CntW-1:0] idx_q;
  logic        ov_q;
  out_item_t   out_q;
  logic        out_free;
  logic [MaxLambdaStates-1:0] hit;

  assign out_free = !ov_q || !out_stall_i;
  assign pop_o    = (state_q == B_IDLE) && !empty_i && out_free;

  always_comb begin
    for (int s = 0; s < MaxLambdaStates; s++) begin
      hit[s] = (rec_i.sel == 3'd0) ? (CntW'(s) < n_i)
             : ((4'(rec_i.sel) <= 4'(n_i)) && (4'(rec_i.sel) == 4'(s + 1)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
      idx_q   <= '0;
      psum_q  <= '0;
      for (int s = 0; s < MaxLambdaStates; s++) ssum_q[s] <= '0;
    end else begin
      if (pop_o || (state_q == B_TOT && out_free)) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            if (rec_i.sel == 3'd0 && n_i == '0) psum_q <= sat_add48(psum_q, rec_i.energy);
            for (int s = 0; s < MaxLambdaStates; s++) begin
              if (hit[s]) ssum_q[s] <= sat_add48(ssum_q[s], rec_i.energy);
            end
            if (rec_i.last) begin
              state_q <= B_TOT;
              idx_q   <= '0;
            end
          end
        end
        B_TOT: begin
          if (out_free) begin
            if (idx_q < n_i) begin
              idx_q <= idx_q + 1'b1;
            end else begin
              psum_q  <= '0;
              for (int s = 0; s < MaxLambdaStates; s++) ssum_q[s] <= '0;
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.kind           <= KIND_FORCE;
      out_q.state_index    <= '0;
      out_q.force_x        <= rec_i.force_x;
      out_q.force_y        <= rec_i.force_y;
      out_q.force_z        <= rec_i.force_z;
      out_q.energy_value   <= rec_i.energy;
      out_q.outside_bounds <= rec_i.outside;
      out_q.last_result    <= !rec_i.last;
    end else if (state_q == B_TOT && out_free) begin
      out_q.force_x        <= '0;
      out_q.force_y        <= '0;
      out_q.force_z        <= '0;
      out_q.outside_bounds <= 1'b0;
      if (idx_q < n_i) begin
        out_q.kind         <= KIND_STATE;
        out_q.state_index  <= 2'(idx_q);
        out_q.energy_value <= ssum_q[idx_q[IdxW-1:0]];
        out_q.last_result  <= 1'b0;
      end else begin
        out_q.kind         <= KIND_PLAIN;
        out_q.state_index  <= '0;
        out_q.energy_value <= psum_q;
        out_q.last_result  <= 1'b1;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/flat_bottom_distance_restraint.sv -----
// ----------------------------------------------------------------------------
// Flat-bottom distance restraint
// Energy and force of harmonic flat-bottom restraints with lambda totals.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_stall_o  | in_data_i  (in_item_t)
//  out     | output    | out_valid_o/out_stall_i| out_data_o (out_item_t)
//  cfg     | input     | psel/penable/pready    | paddr/pwdata/prdata
//
//  One item at a time in the front, through the 34-step square root, up to
//  14 products on the shared multiplier and the 39-step divider. Inside the
//  flat bottom only the three squares are taken; outside at zero distance
//  the force products and the divider are skipped.
//  Back end emits one result a cycle unless stalled; last item adds active
//  states plus one totals. Reset clears all sums at once; no clearing pass.
//  Two-entry queue lets the front run on while the output is stalled.
// ----------------------------------------------------------------------------
`include "flat_bottom_distance_restraint_defines.svh"

module flat_bottom_distance_restraint #(
  parameter int unsigned MaxLambdaStates = fbdr_pkg::MAX_LAMBDA_STATES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fbdr_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fbdr_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import fbdr_pkg::*;

  localparam int unsigned CntW = $clog2(MaxLambdaStates + 1);

  logic [2:0]      count_q;
  logic [16:0]     weight_q [MaxLambdaStates];
  logic            wr;
  logic [2:0]      ridx;
  logic [CntW-1:0] n_act;
  logic            q_push, q_full, q_pop, q_empty;
  frec_t           q_in, q_out;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];
  assign n_act  = (4'(count_q) > 4'(MaxLambdaStates)) ? CntW'(MaxLambdaStates)
                                                       : CntW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < MaxLambdaStates; i++) weight_q[i] <= WEIGHT_ONE;
    end else if (wr) begin
      if (ridx == REG_COUNT) count_q <= pwdata[2:0];
      for (int i = 0; i < MaxLambdaStates; i++) begin
        if (i < NUM_WEIGHT_REGS && 4'(ridx) == 4'(REG_WEIGHT0) + 4'(i))
          weight_q[i] <= pwdata[16:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (ridx == REG_COUNT) prdata = 32'(count_q);
    for (int i = 0; i < MaxLambdaStates; i++) begin
      if (i < NUM_WEIGHT_REGS && 4'(ridx) == 4'(REG_WEIGHT0) + 4'(i))
        prdata = 32'(weight_q[i]);
    end
  end

  fbdr_front #(.MaxLambdaStates(MaxLambdaStates)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .weight_i   (weight_q),
    .push_o     (q_push),
    .rec_o      (q_in),
    .full_i     (q_full)
  );

  fbdr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  fbdr_back #(.MaxLambdaStates(MaxLambdaStates)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_act),
    .empty_i     (q_empty),
    .rec_i       (q_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `FBDR_ASSERT_NEVER(a_no_push_full, q_push && q_full, "push into full queue")
  `FBDR_ASSERT_NEVER(a_no_pop_empty, q_pop && q_empty, "pop from empty queue")
  `FBDR_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "front not busy")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Flat-bottom distance restraint testbench
// Drives restraint items through the block under several lambda settings,
// predicts force, energy and lambda totals in the scoreboard, and checks
// every result in order, with random stalls and idles in the non-calm phases.
// ----------------------------------------------------------------------------
class restraint_scoreboard;
  fbdr_pkg::out_item_t pending_q[$];
  logic [2:0]  lam_count;
  logic [16:0] lam_weight[4];
  logic [47:0] state_sum[4];
  logic [47:0] plain_sum;
  int          errors;
  int          checked;

  function new();
    lam_count = 0;
    for (int i = 0; i < 4; i++) begin
      lam_weight[i] = fbdr_pkg::WEIGHT_ONE;
      state_sum[i]  = '0;
    end
    plain_sum = '0;
    errors    = 0;
    checked   = 0;
  endfunction

  function void write_reg(int idx, logic [31:0] val);
    if (idx == fbdr_pkg::REG_COUNT) lam_count = val[2:0];
    else if (idx >= fbdr_pkg::REG_WEIGHT0 && idx < fbdr_pkg::REG_WEIGHT0 + 4)
      lam_weight[idx - fbdr_pkg::REG_WEIGHT0] = val[16:0];
  endfunction

  function logic [127:0] root_floor(logic [127:0] s);
    logic [127:0] res, c;
    res = '0;
    for (int b = 33; b >= 0; b--) begin
      c = res | (128'd1 << b);
      if (c * c <= s) res = c;
    end
    return res;
  endfunction

  function logic [39:0] axis_force(longint a, logic [16:0] w, logic [31:0] k,
                                   longint dr, logic [127:0] r);
    logic [127:0] am, dm, q, m;
    logic         neg;
    am  = (a < 0) ? -a : a;
    dm  = (dr < 0) ? -dr : dr;
    neg = (a < 0) != (dr < 0);
    q   = (am * w * k * dm) / r;
    m   = q >> 36;
    if (m == 0) return '0;
    if (neg) begin
      if (m > 128'h80_0000_0000) m = 128'h80_0000_0000;
      return -m[39:0];
    end
    return (m > 128'h7F_FFFF_FFFF) ? 40'h7F_FFFF_FFFF : m[39:0];
  endfunction

  function void note_item(fbdr_pkg::in_item_t it);
    fbdr_pkg::out_item_t res;
    longint       a[3], dr;
    logic [127:0] sq, r, dm, e;
    logic [16:0]  w;
    logic [47:0]  energy;
    int           n;
    logic         outside;
    a[0] = longint'(it.second_x) - longint'(it.first_x);
    a[1] = longint'(it.second_y) - longint'(it.first_y);
    a[2] = longint'(it.second_z) - longint'(it.first_z);
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      dm = (a[i] < 0) ? -a[i] : a[i];
      sq += dm * dm;
    end
    r = root_floor(sq);
    n = (lam_count > 4) ? 4 : lam_count;
    outside = 1'b0;
    dr = 0;
    if (r < it.lower_bound) begin
      dr = longint'(r) - longint'(it.lower_bound);
      outside = 1'b1;
    end else if (r > it.upper_bound) begin
      dr = longint'(r) - longint'(it.upper_bound);
      outside = 1'b1;
    end
    res = '0;
    res.kind = fbdr_pkg::KIND_FORCE;
    energy = '0;
    if (outside) begin
      dm = (dr < 0) ? -dr : dr;
      e = (dm * dm * it.spring_const) >> 41;
      energy = (e >> 48) != 0 ? '1 : e[47:0];
      if (it.lambda_select == 0) w = fbdr_pkg::WEIGHT_ONE;
      else if (it.lambda_select <= 4) w = lam_weight[it.lambda_select - 1];
      else w = '0;
      if (r != 0) begin
        res.force_x = axis_force(a[0], w, it.spring_const, dr, r);
        res.force_y = axis_force(a[1], w, it.spring_const, dr, r);
        res.force_z = axis_force(a[2], w, it.spring_const, dr, r);
      end
      if (it.lambda_select == 0) begin
        if (n == 0) plain_sum = fbdr_pkg::sat_add48(plain_sum, energy);
        for (int s = 0; s < n; s++) state_sum[s] = fbdr_pkg::sat_add48(state_sum[s], energy);
      end else if (it.lambda_select <= n) begin
        state_sum[it.lambda_select - 1] =
          fbdr_pkg::sat_add48(state_sum[it.lambda_select - 1], energy);
      end
    end
    res.energy_value   = energy;
    res.outside_bounds = outside;
    res.last_result    = !it.last_item;
    pending_q.push_back(res);
    if (it.last_item) begin
      for (int s = 0; s < n; s++) begin
        res = '0;
        res.kind = fbdr_pkg::KIND_STATE;
        res.state_index = s[1:0];
        res.energy_value = state_sum[s];
        pending_q.push_back(res);
      end
      res = '0;
      res.kind = fbdr_pkg::KIND_PLAIN;
      res.energy_value = plain_sum;
      res.last_result = 1'b1;
      pending_q.push_back(res);
      for (int s = 0; s < 4; s++) state_sum[s] = '0;
      plain_sum = '0;
    end
  endfunction

  function void report(string field, logic [63:0] exp, logic [63:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, exp, got);
    errors++;
  endfunction

  function void check_result(fbdr_pkg::out_item_t got);
    fbdr_pkg::out_item_t exp;
    checked++;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result %h", $realtime, got);
      errors++;
      return;
    end
    exp = pending_q.pop_front();
    if (got.kind != exp.kind)
      report("kind", exp.kind, got.kind);
    if (got.state_index != exp.state_index)
      report("state_index", exp.state_index, got.state_index);
    if (got.force_x != exp.force_x) report("force_x", exp.force_x, got.force_x);
    if (got.force_y != exp.force_y) report("force_y", exp.force_y, got.force_y);
    if (got.force_z != exp.force_z) report("force_z", exp.force_z, got.force_z);
    if (got.energy_value != exp.energy_value)
      report("energy_value", exp.energy_value, got.energy_value);
    if (got.outside_bounds != exp.outside_bounds)
      report("outside_bounds", exp.outside_bounds, got.outside_bounds);
    if (got.last_result != exp.last_result)
      report("last_result", exp.last_result, got.last_result);
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i, rst_ni;
  logic                in_valid_i, in_stall_o;
  fbdr_pkg::in_item_t  in_data_i;
  logic                out_valid_o, out_stall_i;
  fbdr_pkg::out_item_t out_data_o;
  logic                psel, penable, pwrite, pready;
  logic [4:0]          paddr;
  logic [31:0]         pwdata, prdata;

  restraint_scoreboard sb;
  int  items_sent;
  bit  calm;

  flat_bottom_distance_restraint dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("Timeout waiting for results");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int gap_len();
    int p;
    if (calm) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic fbdr_pkg::in_item_t rand_payload();
    logic [319:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
    return fbdr_pkg::in_item_t'(raw[$bits(fbdr_pkg::in_item_t)-1:0]);
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 30);
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);

  task automatic reg_write(int idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 5'(idx * 4); pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_item(fbdr_pkg::in_item_t it);
    int g;
    @(negedge clk_i);
    in_data_i  = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      in_data_i  = rand_payload();
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic fbdr_pkg::in_item_t make_item(logic [31:0] fx, logic [31:0] fy,
      logic [31:0] fz, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
      logic [30:0] lo, logic [30:0] up, logic [31:0] k, logic [2:0] sel, logic last);
    fbdr_pkg::in_item_t it;
    it.first_x = fx; it.first_y = fy; it.first_z = fz;
    it.second_x = sx; it.second_y = sy; it.second_z = sz;
    it.lower_bound = lo; it.upper_bound = up;
    it.spring_const = k; it.lambda_select = sel; it.last_item = last;
    return it;
  endfunction

  function automatic fbdr_pkg::in_item_t rand_item();
    fbdr_pkg::in_item_t it;
    int spread, span;
    it = rand_payload();
    it.lambda_select = $urandom_range(99) < 85 ? 3'($urandom_range(4)) : 3'($urandom);
    it.last_item = ($urandom_range(7) == 0);
    if ($urandom_range(9) < 8) begin
      spread = 1 << $urandom_range(18, 26);
      it.second_x = it.first_x + 32'($signed($urandom_range(0, 2 * spread)) - spread);
      it.second_y = it.first_y + 32'($signed($urandom_range(0, 2 * spread)) - spread);
      it.second_z = it.first_z + 32'($signed($urandom_range(0, 2 * spread)) - spread);
      it.first_x = it.second_x - (it.second_x - it.first_x);
      span = $urandom_range(0, 2 * spread);
      it.lower_bound = 31'(span);
      it.upper_bound = 31'(span + $urandom_range(0, spread));
      if ($urandom_range(9) == 0) it.upper_bound = 31'($urandom_range(0, span));
      it.spring_const = $urandom_range(99) < 80 ? 32'($urandom_range(1, 1 << 24)) : $urandom;
    end
    return it;
  endfunction

  task automatic run_phase(int cnt, logic [31:0] w0, logic [31:0] w1,
                           logic [31:0] w2, logic [31:0] w3, int n_items);
    reg_write(fbdr_pkg::REG_COUNT, cnt);
    reg_write(fbdr_pkg::REG_WEIGHT0 + 0, w0);
    reg_write(fbdr_pkg::REG_WEIGHT0 + 1, w1);
    reg_write(fbdr_pkg::REG_WEIGHT0 + 2, w2);
    reg_write(fbdr_pkg::REG_WEIGHT0 + 3, w3);
    for (int i = 0; i < n_items; i++) begin
      fbdr_pkg::in_item_t it;
      it = rand_item();
      if (i == n_items - 1) it.last_item = 1'b1;
      send_item(it);
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
    drain();
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    calm = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: default registers, then all four states active
    send_item(make_item(0, 0, 0, 0, 0, 0, 31'd1 << 20, 31'd2 << 20, 32'hFFFF_FFFF, 0, 0));
    send_item(make_item(5, 5, 5, 5, 5, 5, 0, 0, 32'h0001_0000, 0, 0));
    send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        0, 0, 32'hFFFF_FFFF, 0, 0));
    send_item(make_item(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0,
                        32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    send_item(make_item(0, 0, 0, 32'd3 << 20, 0, 0, 31'd1 << 20, 31'd2 << 20,
                        32'h0010_0000, 0, 0));
    send_item(make_item(0, 0, 0, 0, 32'd1 << 19, 0, 31'd1 << 20, 31'd2 << 20,
                        32'h0010_0000, 0, 0));
    send_item(make_item(0, 0, 0, 0, 0, 32'd3 << 19, 31'd3 << 20, 31'd1 << 20,
                        32'h0010_0000, 0, 0));
    send_item(make_item(0, 0, 0, 0, 0, 32'd3 << 20, 31'd1 << 20, 31'd2 << 20,
                        32'h0010_0000, 0, 1));
    @(negedge clk_i);
    in_valid_i = 1'b0;
    drain();
    reg_write(fbdr_pkg::REG_COUNT, 4);
    reg_write(fbdr_pkg::REG_WEIGHT0 + 1, 0);
    reg_write(fbdr_pkg::REG_WEIGHT0 + 2, 17'h1FFFF);
    reg_write(fbdr_pkg::REG_WEIGHT0 + 3, 32'd32768);
    for (int s = 0; s < 8; s++)
      send_item(make_item(32'h0010_0000, 32'hFFF0_0000, 0, 32'hFFE0_0000, 32'h0030_0000,
                          32'h0100_0000, 31'd1 << 20, 31'd2 << 20, 32'h0040_0000,
                          3'(s), s == 7));
    send_item(make_item(1, 2, 3, 4, 5, 6, 31'd1 << 20, 31'd2 << 20, 32'h0001_0000, 0, 1));
    @(negedge clk_i);
    in_valid_i = 1'b0;
    drain();

    calm = 1'b0;
    run_phase(0, 65536, 65536, 65536, 65536, 20);
    run_phase(4, 0, 65536, 32'($urandom_range(65536)), 32'($urandom_range(65536)), 25);
    calm = 1'b1;
    run_phase(2, 32'($urandom_range(65536)), 12345, 65536, 0, 15);
    calm = 1'b0;
    run_phase(7, 65536, 0, 32'($urandom_range(65536)), 65536, 20);
    run_phase(1, 32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom), 20);

    $display("Covered %0d restraint items and %0d results over seven lambda setups,",
             items_sent, sb.checked);
    $display("including zero distance, crossed bounds, saturation and unused selectors.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/fbdr_pkg.sv
hw/rtl/fbdr_mul.sv
hw/rtl/fbdr_front.sv
hw/rtl/fbdr_queue.sv
hw/rtl/fbdr_back.sv
hw/rtl/flat_bottom_distance_restraint.sv
tb/testbench.sv
